// ----- design/fras_pkg.sv -----
// Package for the FIFO-ordered resource allocator with usage statistics.
// Holds sizes, field codes, payload structs and the back-end state type.
// No dependencies.
package fras_pkg;

  localparam int RESOURCES   = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int CMDQ_DEPTH  = 2;

  localparam int RES_IDX_W = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int CQPTR_W   = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CQCNT_W   = $clog2(CMDQ_DEPTH + 1);

  localparam logic [1:0] ACT_REQUEST = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_REPORT  = 2'd2;

  localparam logic [1:0] KIND_GRANT  = 2'd0;
  localparam logic [1:0] KIND_ROW    = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  requester;
    logic [15:0] duration;
    logic [2:0]  resource;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  granted_requester;
    logic [2:0]  granted_resource;
    logic [31:0] use_count;
    logic [47:0] time_total;
    logic [15:0] time_average;
    logic [31:0] waited_total;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_REQUEST,
    OP_RELEASE,
    OP_REPORT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  requester;
    logic [15:0] duration;
    logic [2:0]  resource;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  requester;
    logic [15:0] duration;
  } waiter_t;

  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

endpackage

// ----- design/fras_if.sv -----
// Valid/ready channel interfaces for input items, commands and results.
// Depends on fras_pkg.
interface fras_in_if
  import fras_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fras_cmd_if
  import fras_pkg::*;
();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fras_out_if
  import fras_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/fras_front.sv -----
// Front end: accepts input items, decodes the action and drops items that
// have no effect. Depends on fras_pkg and fras_if.
module fras_front
  import fras_pkg::*;
(
  fras_in_if.sink    item,
  fras_cmd_if.source cmd
);

  logic keep;

  always_comb begin
    keep                = 1'b0;
    cmd.data.op         = OP_REQUEST;
    cmd.data.requester  = item.data.requester;
    cmd.data.duration   = item.data.duration;
    cmd.data.resource   = item.data.resource;
    case (item.data.action)
      ACT_REQUEST: begin
        keep        = 1'b1;
        cmd.data.op = OP_REQUEST;
      end
      ACT_RELEASE: begin
        keep        = (32'(item.data.resource) < RESOURCES);
        cmd.data.op = OP_RELEASE;
      end
      ACT_REPORT: begin
        keep        = 1'b1;
        cmd.data.op = OP_REPORT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmd.valid  = item.valid && keep;
  assign item.ready = cmd.ready || !keep;

endmodule

// ----- design/fras_cmd_queue.sv -----
// Short command queue between the front and back ends.
// Depends on fras_pkg and fras_if.
module fras_cmd_queue
  import fras_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fras_cmd_if.sink   wr,
  fras_cmd_if.source rd
);

  cmd_t               slots [CMDQ_DEPTH];
  logic [CQPTR_W-1:0] wptr;
  logic [CQPTR_W-1:0] rptr;
  logic [CQCNT_W-1:0] count;
  logic               push;
  logic               pop;

  assign wr.ready = (count != CQCNT_W'(CMDQ_DEPTH));
  assign rd.valid = (count != '0);
  assign rd.data  = slots[rptr];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wptr] <= wr.data;
        wptr        <= (wptr == CQPTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr + CQPTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == CQPTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr + CQPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CQCNT_W'(1);
        2'b01:   count <= count - CQCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/fras_divider.sv -----
// Bit-serial divider for the report average: 48-bit total over 32-bit count,
// 16-bit saturating quotient, zero for a zero count. Depends on fras_pkg.
module fras_divider
  import fras_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [31:0] rem;
  logic [15:0] low;
  logic [31:0] divisor;
  logic [15:0] quot;
  logic [4:0]  steps;
  logic        done;
  logic [32:0] trial;
  logic        qbit;

  assign trial = {rem, low[15]};
  assign qbit  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      if (req.start) begin
        divisor <= req.divisor;
        if (req.divisor == '0) begin
          quot <= '0;
          done <= 1'b1;
        end else if (req.dividend[47:16] >= req.divisor) begin
          quot <= '1;
          done <= 1'b1;
        end else begin
          rem   <= req.dividend[47:16];
          low   <= req.dividend[15:0];
          steps <= 5'd16;
          done  <= 1'b0;
        end
      end else if (steps != '0) begin
        rem   <= qbit ? 32'(trial - {1'b0, divisor}) : trial[31:0];
        low   <= {low[14:0], 1'b0};
        quot  <= {quot[14:0], qbit};
        steps <= steps - 5'd1;
        done  <= (steps == 5'd1);
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

// ----- design/fras_back.sv -----
// Back end: wait queue, resource map, usage statistics and the result register.
// Depends on fras_pkg and fras_if.
module fras_back
  import fras_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fras_cmd_if.sink   cmd,
  fras_out_if.source result,
  output div_req_t   div_req,
  input  div_rsp_t   div_rsp
);

  state_t               state;
  state_t               state_next;
  waiter_t              mem [QUEUE_DEPTH];
  waiter_t              rd_data;
  logic [QCNT_W-1:0]    fifo_count;
  logic [QPTR_W-1:0]    head;
  logic [QPTR_W-1:0]    tail;
  logic [RESOURCES-1:0] free_map;
  logic [31:0]          grant_counts [RESOURCES];
  logic [47:0]          time_totals [RESOURCES];
  logic [31:0]          wait_counter;
  logic [RES_IDX_W-1:0] idx;
  logic [7:0]           req_q;
  logic [15:0]          dur_q;
  out_item_t            res_q;
  logic                 out_valid;
  out_item_t            out_data;

  logic                 take;
  logic                 full;
  logic                 has_free;
  logic [RES_IDX_W-1:0] low_free;
  logic [RES_IDX_W-1:0] rel_idx;
  logic                 slot_free;
  logic                 emit_fire;
  logic                 more_rows;
  logic [48:0]          sum;

  always_comb begin
    low_free = '0;
    for (int i = RESOURCES - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        low_free = RES_IDX_W'(i);
      end
    end
  end

  assign full      = (fifo_count == QCNT_W'(QUEUE_DEPTH));
  assign has_free  = |free_map;
  assign rel_idx   = RES_IDX_W'(cmd.data.resource);
  assign slot_free = !out_valid || result.ready;
  assign more_rows = (res_q.kind == KIND_ROW) && !res_q.last;
  assign sum       = {1'b0, time_totals[idx]} + 49'(dur_q);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          case (cmd.data.op)
            OP_REQUEST: begin
              if (full) begin
                state_next = ST_EMIT;
              end else if (has_free) begin
                state_next = ST_UPDATE;
              end
            end
            OP_RELEASE: begin
              if (!free_map[rel_idx] && fifo_count != '0) begin
                state_next = ST_READ;
              end
            end
            OP_REPORT: state_next = ST_DIV_START;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ:      state_next = ST_UPDATE;
      ST_UPDATE:    state_next = ST_EMIT;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_next = more_rows ? ST_DIV_START : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready        = (state == ST_IDLE);
    div_req.start    = (state == ST_DIV_START);
    div_req.dividend = time_totals[idx];
    div_req.divisor  = grant_counts[idx];
    emit_fire        = (state == ST_EMIT) && slot_free;
  end

  assign take = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_count   <= '0;
      head         <= '0;
      tail         <= '0;
      free_map     <= '1;
      wait_counter <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < RESOURCES; i++) begin
        grant_counts[i] <= '0;
        time_totals[i]  <= '0;
      end
    end else begin
      if (take) begin
        case (cmd.data.op)
          OP_REQUEST: begin
            if (full) begin
              res_q <= '{kind: KIND_REJECT, granted_requester: cmd.data.requester,
                         granted_resource: '0, use_count: '0, time_total: '0,
                         time_average: '0, waited_total: '0, last: 1'b1};
            end else if (has_free) begin
              idx   <= low_free;
              req_q <= cmd.data.requester;
              dur_q <= cmd.data.duration;
            end else begin
              mem[tail]  <= '{requester: cmd.data.requester, duration: cmd.data.duration};
              tail       <= (tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + QPTR_W'(1);
              fifo_count <= fifo_count + QCNT_W'(1);
              if (wait_counter != '1) begin
                wait_counter <= wait_counter + 32'd1;
              end
            end
          end
          OP_RELEASE: begin
            if (!free_map[rel_idx]) begin
              free_map[rel_idx] <= 1'b1;
              idx               <= rel_idx;
              rd_data           <= mem[head];
            end
          end
          OP_REPORT: begin
            idx <= '0;
          end
          default: begin
            idx <= idx;
          end
        endcase
      end

      if (state == ST_READ) begin
        req_q      <= rd_data.requester;
        dur_q      <= rd_data.duration;
        head       <= (head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + QPTR_W'(1);
        fifo_count <= fifo_count - QCNT_W'(1);
      end

      if (state == ST_UPDATE) begin
        free_map[idx] <= 1'b0;
        if (grant_counts[idx] != '1) begin
          grant_counts[idx] <= grant_counts[idx] + 32'd1;
        end
        time_totals[idx] <= sum[48] ? '1 : sum[47:0];
        res_q <= '{kind: KIND_GRANT, granted_requester: req_q,
                   granted_resource: 3'(idx), use_count: '0, time_total: '0,
                   time_average: '0, waited_total: '0, last: 1'b1};
      end

      if (state == ST_DIV_WAIT && div_rsp.done) begin
        res_q <= '{kind: KIND_ROW, granted_requester: '0,
                   granted_resource: 3'(idx), use_count: grant_counts[idx],
                   time_total: time_totals[idx], time_average: div_rsp.quotient,
                   waited_total: wait_counter,
                   last: (idx == RES_IDX_W'(RESOURCES - 1))};
      end

      if (emit_fire) begin
        out_valid <= 1'b1;
        out_data  <= res_q;
        if (more_rows) begin
          idx <= idx + RES_IDX_W'(1);
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

// ----- design/fifo_resource_allocator_with_stats_core.sv -----
// FIFO-ordered first-free resource allocator with usage statistics.
// A rejection goes straight to emit, a grant on request passes update first, and
// a grant on release passes read and update. One command is carried out at a time.
// A report gives 8 rows, each through the one-bit-per-cycle divider for the
// average, which does no division steps for a row whose resource is unused or saturates.
// Reset: synchronous, active high; all resources free, statistics zero,
// wait queue empty. No clearing pass. Depends on fras_pkg, fras_if and all fras_* modules.
module fifo_resource_allocator_with_stats_core
  import fras_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fras_in_if.sink    item,
  fras_out_if.source result
);

  fras_cmd_if cmd_front ();
  fras_cmd_if cmd_back ();
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  fras_front u_front (
    .item (item),
    .cmd  (cmd_front)
  );

  fras_cmd_queue u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (cmd_front),
    .rd  (cmd_back)
  );

  fras_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  fras_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_back),
    .result  (result),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

endmodule
